### rtl/core/ssp_pkg.sv
// Shared types and constants of the scan station peak finder.
// No dependencies; imported by every module of the core.
package ssp_pkg;

	// Input function codes
	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_REPORT = 2'd2;

	// Configuration register indexes
	localparam logic CFG_START_FREQ = 1'b0;
	localparam logic CFG_FREQ_STEP  = 1'b1;

	// Threshold: lowest + (highest - lowest) / 3, the divide done as d * 171 >> 9
	localparam int         TH_RECIP     = 171;
	localparam int         TH_SHIFT     = 9;
	localparam logic [8:0] FLAT_MARGIN  = 9'd2;
	localparam logic [7:0] STRENGTH_MAX = 8'hFF;

	// One stored scan point
	typedef struct packed {
		logic [7:0] noise_ratio;
		logic [7:0] strength;
	} point_t;

	// One station list entry
	typedef struct packed {
		logic [7:0]  noise_ratio;
		logic [7:0]  strength;
		logic [15:0] frequency;
	} station_t;

	// Scan status from the point store
	typedef struct packed {
		logic       present;
		logic [7:0] lowest;
		logic [7:0] highest;
	} pts_status_t;

	// Report sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RD,
		ST_EVAL,
		ST_FREQ,
		ST_INS,
		ST_WAIT,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMPTY
	} ctl_state_t;

	// Station list insertion sequencer
	typedef enum logic [1:0] {
		LS_IDLE,
		LS_SHIFT,
		LS_CMP,
		LS_FULL_CHK
	} lst_state_t;

endpackage

### rtl/core/ssp_point_store.sv
// Point store: scan point memory, fill count and strength extremes.
// Depends on ssp_pkg.
module ssp_point_store import ssp_pkg::*; #(
	parameter int MAX_POINTS = 256,
	localparam int PAW = $clog2(MAX_POINTS),
	localparam int PCW = $clog2(MAX_POINTS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            add,
	input  point_t          add_point,
	input  logic            rd_en,
	input  logic [PAW-1:0]  rd_addr,
	output point_t          rd_data,
	output logic [PCW-1:0]  count,
	output pts_status_t     status
);

	point_t             mem [MAX_POINTS];
	point_t             rd_q;
	logic [PCW-1:0]     count_q;
	pts_status_t        status_q;
	logic               do_add;

	// points past the store depth, or before any start, are dropped
	assign do_add = add && status_q.present && (count_q < PCW'(MAX_POINTS));

	// count and extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= '{present: 1'b0, lowest: STRENGTH_MAX, highest: 8'd0};
		end else if (start) begin
			count_q  <= '0;
			status_q <= '{present: 1'b1, lowest: STRENGTH_MAX, highest: 8'd0};
		end else if (do_add) begin
			count_q <= count_q + PCW'(1);
			if (add_point.strength < status_q.lowest)
				status_q.lowest <= add_point.strength;
			if (add_point.strength > status_q.highest)
				status_q.highest <= add_point.strength;
		end
	end

	// point memory, registered read
	always_ff @(posedge clk) begin
		if (do_add)
			mem[count_q[PAW-1:0]] <= add_point;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
	assign count   = count_q;
	assign status  = status_q;

endmodule

### rtl/core/ssp_station_list.sv
// Station list: strength-sorted memory with a one-step-per-pass insertion sequencer.
// Depends on ssp_pkg.
module ssp_station_list import ssp_pkg::*; #(
	parameter int MAX_STATIONS = 20,
	localparam int LAW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1,
	localparam int LCW = $clog2(MAX_STATIONS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clear,
	input  logic            ins,
	input  station_t        ins_entry,
	output logic            busy,
	output logic [LCW-1:0]  count,
	input  logic            rd_en,
	input  logic [LAW-1:0]  rd_addr,
	output station_t        rd_data
);

	localparam logic [LAW-1:0] LAST_ADDR = LAW'(MAX_STATIONS - 1);

	station_t           mem [MAX_STATIONS];
	station_t           rd_q;
	lst_state_t         state_q, state_d;
	logic [LAW-1:0]     pos_q, pos_d;
	logic [LCW-1:0]     cnt_q, cnt_d;
	station_t           ent_q, ent_d;
	logic               we;
	logic [LAW-1:0]     waddr;
	station_t           wdata;
	logic               mrd_en;
	logic [LAW-1:0]     mrd_addr;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		ent_q <= ent_d;
	end

	// insertion: walk up from the free slot, moving weaker entries down one place
	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		ent_d    = ent_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = ent_q;
		mrd_en   = rd_en;
		mrd_addr = rd_addr;
		case (state_q)
			LS_IDLE: begin
				if (clear) begin
					cnt_d = '0;
				end else if (ins) begin
					ent_d = ins_entry;
					if (cnt_q >= LCW'(MAX_STATIONS)) begin
						// full: look at the weakest entry first
						mrd_en   = 1'b1;
						mrd_addr = LAST_ADDR;
						state_d  = LS_FULL_CHK;
					end else begin
						pos_d   = cnt_q[LAW-1:0];
						cnt_d   = cnt_q + LCW'(1);
						state_d = LS_SHIFT;
					end
				end
			end
			LS_SHIFT: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = LS_IDLE;
				end else begin
					mrd_en   = 1'b1;
					mrd_addr = pos_q - LAW'(1);
					state_d  = LS_CMP;
				end
			end
			LS_CMP: begin
				we = 1'b1;
				if (rd_q.strength < ent_q.strength) begin
					wdata   = rd_q;
					pos_d   = pos_q - LAW'(1);
					state_d = LS_SHIFT;
				end else begin
					state_d = LS_IDLE;
				end
			end
			LS_FULL_CHK: begin
				// only a strictly stronger station displaces the weakest
				if (rd_q.strength >= ent_q.strength) begin
					state_d = LS_IDLE;
				end else begin
					pos_d   = LAST_ADDR;
					state_d = LS_SHIFT;
				end
			end
			default: begin
				state_d = LS_IDLE;
			end
		endcase
	end

	// list memory, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (mrd_en)
			rd_q <= mem[mrd_addr];
	end

	assign busy    = (state_q != LS_IDLE);
	assign count   = cnt_q;
	assign rd_data = rd_q;

endmodule

### rtl/core/scan_station_peak_finder_core.sv
// Scan station peak finder, top level: input decode, report sequencer, output register.
// Depends on ssp_pkg, ssp_point_store and ssp_station_list.
//
// Start and add-point beats are taken one per cycle, back to back. A report beat
// holds the input stalled while the sequencer walks the point store through its single
// registered read port, one read and one evaluation (ST_RD, ST_EVAL) per stored point.
// Each station found has its frequency formed (ST_FREQ) and is handed over (ST_INS);
// the sequencer then waits (ST_WAIT) for its insertion into the sorted list, which moves
// each weaker entry down one place and, when the list is already full, first checks the
// weakest entry. Results then leave one at a time, one list memory read each, and wait
// while the output is stalled. A flat band or missing scan gives its single empty result.
// No memory needs clearing after reset.
module scan_station_peak_finder_core import ssp_pkg::*; #(
	parameter int MAX_POINTS   = 256,
	parameter int MAX_STATIONS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  strength,
	input  logic [7:0]  noise_ratio,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] station_frequency,
	output logic [7:0]  station_strength,
	output logic [7:0]  station_noise_ratio,
	output logic        station_valid,
	output logic [4:0]  station_total,
	output logic        last_of_report
);

	localparam int PAW = $clog2(MAX_POINTS);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int LAW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam int LCW = $clog2(MAX_STATIONS + 1);

	ctl_state_t         state_q, state_d;
	logic [15:0]        cfg_start_q;
	logic [15:0]        cfg_step_q;
	logic               in_acc;
	logic               pts_start;
	logic               pts_add;
	logic               pts_rd_en;
	point_t             pts_rd;
	logic [PCW-1:0]     pts_count;
	pts_status_t        pts_stat;
	logic               lst_clear;
	logic               lst_ins;
	logic               lst_busy;
	logic [LCW-1:0]     lst_count;
	logic               lst_rd_en;
	station_t           lst_rd;
	logic [PCW-1:0]     i_q;
	logic [LCW-1:0]     k_q;
	logic               run_q;
	point_t             best_q;
	logic [PAW-1:0]     best_idx_q;
	logic [7:0]         th_q;
	station_t           ent_q;
	logic [7:0]         diff;
	logic [16:0]        third;
	logic               flat;
	logic               above;
	logic               take;
	logic               walk_end;
	logic               out_free;
	logic               out_load;
	logic               out_empty;
	logic               k_last;
	logic [15:0]        freq_mul;
	logic               out_valid_q;
	station_t           out_ent_q;
	logic               out_sv_q;
	logic [4:0]         out_total_q;
	logic               out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q <= 16'd0;
			cfg_step_q  <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_FREQ: cfg_start_q <= cfg_data;
				CFG_FREQ_STEP:  cfg_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign pts_start = in_acc && (func == FUNC_START);
	assign pts_add   = in_acc && (func == FUNC_ADD);

	ssp_point_store #(.MAX_POINTS(MAX_POINTS)) u_pts (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pts_start),
		.add       (pts_add),
		.add_point ({noise_ratio, strength}),
		.rd_en     (pts_rd_en),
		.rd_addr   (i_q[PAW-1:0]),
		.rd_data   (pts_rd),
		.count     (pts_count),
		.status    (pts_stat)
	);

	ssp_station_list #(.MAX_STATIONS(MAX_STATIONS)) u_lst (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (lst_clear),
		.ins       (lst_ins),
		.ins_entry (ent_q),
		.busy      (lst_busy),
		.count     (lst_count),
		.rd_en     (lst_rd_en),
		.rd_addr   (k_q[LAW-1:0]),
		.rd_data   (lst_rd)
	);

	// threshold and run detection terms
	assign diff      = pts_stat.highest - pts_stat.lowest;
	assign third     = 17'(diff) * 17'(TH_RECIP);
	assign flat      = !pts_stat.present ||
	                   ({1'b0, pts_stat.highest} <= ({1'b0, pts_stat.lowest} + FLAT_MARGIN));
	assign above     = (pts_rd.strength >= th_q);
	assign take      = above && (!run_q || (pts_rd.strength > best_q.strength));
	assign walk_end  = (i_q == pts_count);
	assign freq_mul  = cfg_step_q * 16'(best_idx_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign k_last    = ((k_q + LCW'(1)) == lst_count);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		pts_rd_en = 1'b0;
		lst_clear = 1'b0;
		lst_ins   = 1'b0;
		lst_rd_en = 1'b0;
		out_load  = 1'b0;
		out_empty = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (func == FUNC_REPORT))
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				lst_clear = 1'b1;
				state_d   = flat ? ST_EMPTY : ST_RD;
			end
			ST_RD: begin
				if (walk_end) begin
					if (run_q)
						state_d = ST_FREQ;
					else if (lst_count == '0)
						state_d = ST_EMPTY;
					else
						state_d = ST_EMIT_RD;
				end else begin
					pts_rd_en = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = (!above && run_q) ? ST_FREQ : ST_RD;
			end
			ST_FREQ: begin
				state_d = ST_INS;
			end
			ST_INS: begin
				lst_ins = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!lst_busy)
					state_d = ST_RD;
			end
			ST_EMIT_RD: begin
				lst_rd_en = 1'b1;
				state_d   = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = k_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_empty = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// scan walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
			k_q   <= '0;
		end else begin
			case (state_q)
				ST_SETUP: begin
					run_q <= 1'b0;
					i_q   <= '0;
					k_q   <= '0;
				end
				ST_RD: begin
					if (walk_end)
						run_q <= 1'b0;
				end
				ST_EVAL: begin
					i_q   <= i_q + PCW'(1);
					run_q <= above;
				end
				ST_EMIT_LD: begin
					if (out_free)
						k_q <= k_q + LCW'(1);
				end
				default: ;
			endcase
		end
	end

	// best point of the run, threshold and list entry
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP)
			th_q <= pts_stat.lowest + third[TH_SHIFT+7:TH_SHIFT];
		if ((state_q == ST_EVAL) && take) begin
			best_q     <= pts_rd;
			best_idx_q <= i_q[PAW-1:0];
		end
		if (state_q == ST_FREQ) begin
			ent_q.noise_ratio <= best_q.noise_ratio;
			ent_q.strength    <= best_q.strength;
			ent_q.frequency   <= cfg_start_q + freq_mul;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (out_empty) begin
				out_ent_q   <= '0;
				out_sv_q    <= 1'b0;
				out_total_q <= 5'd0;
				out_last_q  <= 1'b1;
			end else begin
				out_ent_q   <= lst_rd;
				out_sv_q    <= 1'b1;
				out_total_q <= 5'(lst_count);
				out_last_q  <= k_last;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign station_frequency   = out_ent_q.frequency;
	assign station_strength    = out_ent_q.strength;
	assign station_noise_ratio = out_ent_q.noise_ratio;
	assign station_valid       = out_sv_q;
	assign station_total       = out_total_q;
	assign last_of_report      = out_last_q;

endmodule

### tb/scan_station_peak_finder_core_test.sv
// Self-checking testbench for scan_station_peak_finder_core: a directed stimulus table, then
// random scans, checked against an in-bench station predictor and typed-in empty reports.
// Depends on ssp_pkg and the core RTL.
module scan_station_peak_finder_core_test import ssp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PTS     = 256;
	localparam int MAX_ST      = 20;
	localparam int QUIET_LIMIT = 20000;  // cycles with no beat on either channel
	localparam int SETTLE      = 16;     // block is idle this long after its last result

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// One result beat as the block presents it
	typedef struct packed {
		logic [15:0] frequency;
		logic [7:0]  strength;
		logic [7:0]  noise_ratio;
		logic        is_station;
		logic [4:0]  total;
		logic        is_last;
	} station_beat_t;

	// One row of the directed stimulus
	typedef struct packed {
		logic [1:0]    func_code;
		logic [7:0]    str;
		logic [7:0]    snr;
		logic          typed;
		station_beat_t want;
	} dir_row_t;

	localparam station_beat_t NO_RESULT    = '0;
	localparam station_beat_t EMPTY_REPORT = {16'd0, 8'd0, 8'd0, 1'b0, 5'd0, 1'b1};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_START_FREQ;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FUNC_START;
	logic [7:0]  strength = '0;
	logic [7:0]  noise_ratio = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] station_frequency;
	logic [7:0]  station_strength;
	logic [7:0]  station_noise_ratio;
	logic        station_valid;
	logic [4:0]  station_total;
	logic        last_of_report;

	scan_station_peak_finder_core #(
		.MAX_POINTS  (MAX_PTS),
		.MAX_STATIONS(MAX_ST)
	) DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.func               (func),
		.strength           (strength),
		.noise_ratio        (noise_ratio),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.station_frequency  (station_frequency),
		.station_strength   (station_strength),
		.station_noise_ratio(station_noise_ratio),
		.station_valid      (station_valid),
		.station_total      (station_total),
		.last_of_report     (last_of_report)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: scan contents, band limits, registers, ranked station list
	logic [7:0]    scan_str [MAX_PTS];
	logic [7:0]    scan_snr [MAX_PTS];
	int            scan_len;
	logic [7:0]    band_low;
	logic [7:0]    band_high;
	logic          scan_open;
	logic [15:0]   freq_base;
	logic [15:0]   freq_step;
	station_beat_t ranked [MAX_ST];

	station_beat_t expected_stations [$];
	int            mismatches;
	int            quiet_cycles;
	int            send_idle_pct;
	int            stall_pct;
	int            beats_sent;
	station_beat_t got;
	station_beat_t want;

	// Directed rows: empty reports are typed in, the rest go through the predictor
	dir_row_t directed_rows [25] = '{
		{FUNC_REPORT, 8'd0,   8'd0,   1'b1, EMPTY_REPORT},  // report before any scan
		{FUNC_ADD,    8'd255, 8'd255, 1'b0, NO_RESULT},     // point without a scan: dropped
		{FUNC_UNUSED, 8'd255, 8'd255, 1'b0, NO_RESULT},
		{FUNC_REPORT, 8'd0,   8'd0,   1'b1, EMPTY_REPORT},
		{FUNC_START,  8'd0,   8'd0,   1'b0, NO_RESULT},
		{FUNC_REPORT, 8'd0,   8'd0,   1'b1, EMPTY_REPORT},  // open scan, no points
		{FUNC_ADD,    8'd10,  8'd0,   1'b0, NO_RESULT},
		{FUNC_ADD,    8'd12,  8'd255, 1'b0, NO_RESULT},
		{FUNC_ADD,    8'd11,  8'd1,   1'b0, NO_RESULT},
		{FUNC_REPORT, 8'd0,   8'd0,   1'b1, EMPTY_REPORT},  // flat band, spread of two
		{FUNC_ADD,    8'd0,   8'h55,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd255, 8'hAA,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd255, 8'hFF,  1'b0, NO_RESULT},     // tie inside a run
		{FUNC_ADD,    8'd0,   8'h0F,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd200, 8'hF0,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd0,   8'h33,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd255, 8'hCC,  1'b0, NO_RESULT},     // run reaching the scan end
		{FUNC_REPORT, 8'd0,   8'd0,   1'b0, NO_RESULT},
		{FUNC_REPORT, 8'hFF,  8'hFF,  1'b0, NO_RESULT},     // repeated report
		{FUNC_START,  8'hFF,  8'hFF,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd0,   8'h80,  1'b0, NO_RESULT},
		{FUNC_ADD,    8'd3,   8'h01,  1'b0, NO_RESULT},     // spread of three: not flat
		{FUNC_ADD,    8'd1,   8'h7F,  1'b0, NO_RESULT},     // exactly at threshold
		{FUNC_REPORT, 8'd0,   8'd0,   1'b0, NO_RESULT},
		{FUNC_UNUSED, 8'd0,   8'd0,   1'b0, NO_RESULT}
	};

	// Station predictor: updates the scan and, on a report, queues the expected beats
	function automatic void predict_stations(input logic [1:0] f, input logic [7:0] s,
			input logic [7:0] n, input bit record);
		int            i;
		int            best;
		int            pos;
		int            cnt;
		logic [7:0]    th;
		station_beat_t ent;
		case (f)
			FUNC_START: begin
				scan_len  = 0;
				band_low  = STRENGTH_MAX;
				band_high = 8'd0;
				scan_open = 1'b1;
			end
			FUNC_ADD: begin
				if (scan_open && scan_len < MAX_PTS) begin
					scan_str[scan_len] = s;
					scan_snr[scan_len] = n;
					scan_len++;
					if (s < band_low) band_low = s;
					if (s > band_high) band_high = s;
				end
			end
			FUNC_REPORT: begin
				cnt = 0;
				if (scan_open && int'(band_high) > int'(band_low) + 2) begin
					th = band_low + (band_high - band_low) / 8'd3;
					i = 0;
					while (i < scan_len) begin
						if (scan_str[i] < th) begin
							i++;
						end else begin
							// walk the run, keep its first strongest point
							best = i;
							while (i < scan_len && scan_str[i] >= th) begin
								if (scan_str[i] > scan_str[best]) best = i;
								i++;
							end
							ent = NO_RESULT;
							ent.frequency   = 16'(freq_base + freq_step * best);
							ent.strength    = scan_str[best];
							ent.noise_ratio = scan_snr[best];
							// full list: only a strictly stronger station gets in
							if (cnt < MAX_ST || ent.strength > ranked[MAX_ST-1].strength) begin
								if (cnt < MAX_ST) begin
									pos = cnt;
									cnt++;
								end else begin
									pos = MAX_ST - 1;
								end
								while (pos > 0 && ranked[pos-1].strength < ent.strength) begin
									ranked[pos] = ranked[pos-1];
									pos--;
								end
								ranked[pos] = ent;
							end
						end
					end
				end
				if (record) begin
					if (cnt == 0) begin
						expected_stations.push_back(EMPTY_REPORT);
					end else begin
						for (i = 0; i < cnt; i++) begin
							ent = ranked[i];
							ent.is_station = 1'b1;
							ent.total      = 5'(cnt);
							ent.is_last    = (i == cnt - 1);
							expected_stations.push_back(ent);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Drive one input beat and hold it until accepted
	task automatic send_beat(input logic [1:0] f, input logic [7:0] s, input logic [7:0] n,
			input bit typed = 1'b0, input station_beat_t typed_want = NO_RESULT);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		strength    <= s;
		noise_ratio <= n;
		do @(posedge clk); while (in_stall);
		predict_stations(f, s, n, !typed);
		if (typed) expected_stations.push_back(typed_want);
		if (f != FUNC_UNUSED) beats_sent++;
	endtask

	// Hold off input until every expected beat is out, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_stations.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START_FREQ) freq_base = value;
		else freq_step = value;
	endtask

	// One scan: start, points shaped by profile, usually a report; with some noise mixed in
	task automatic run_scan(input int profile, input int npts);
		int         k;
		int         lvl;
		logic [7:0] s;
		lvl = $urandom_range(0, 252);
		send_beat(FUNC_START, 8'($urandom), 8'($urandom));
		for (k = 0; k < npts; k++) begin
			case (profile)
				0: s = 8'($urandom_range(0, 255));
				// alternating low/high: many stations, frequent strength ties
				1: s = k[0] ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 60));
				// nearly flat band, spread up to three
				2: s = 8'(lvl + $urandom_range(0, 3));
				default: begin
					lvl = lvl + int'($urandom_range(0, 60)) - 30;
					if (lvl < 0) lvl = 0;
					if (lvl > 255) lvl = 255;
					s = 8'(lvl);
				end
			endcase
			send_beat(FUNC_ADD, s, 8'($urandom));
			if ($urandom_range(99) < 4) send_beat(FUNC_UNUSED, 8'($urandom), 8'($urandom));
			if ($urandom_range(99) < 3) send_beat(FUNC_REPORT, 8'($urandom), 8'($urandom));
		end
		// sometimes the scan is abandoned, sometimes reported twice
		if ($urandom_range(9) != 0) send_beat(FUNC_REPORT, 8'($urandom), 8'($urandom));
		if ($urandom_range(3) == 0) send_beat(FUNC_REPORT, 8'($urandom), 8'($urandom));
	endtask

	task automatic run_random(input int target);
		int first;
		first = beats_sent;
		while (beats_sent - first < target) begin
			run_scan($urandom_range(0, 3),
				($urandom_range(9) == 0) ? $urandom_range(41, 80) : $urandom_range(0, 24));
		end
	endtask

	// Result side: random stall, check each beat against the oldest expectation
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			got = {station_frequency, station_strength, station_noise_ratio, station_valid,
				station_total, last_of_report};
			if (expected_stations.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: freq %h str %h snr %h valid %b total %0d last %b",
						got.frequency, got.strength, got.noise_ratio, got.is_station,
						got.total, got.is_last);
			end else begin
				want = expected_stations.pop_front();
				if (got.frequency !== want.frequency || got.strength !== want.strength ||
						got.noise_ratio !== want.noise_ratio ||
						got.is_station !== want.is_station || got.total !== want.total ||
						got.is_last !== want.is_last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected freq %h str %h snr %h valid %b total %0d last %b",
							want.frequency, want.strength, want.noise_ratio, want.is_station,
							want.total, want.is_last);
						$display("          got      freq %h str %h snr %h valid %b total %0d last %b",
							got.frequency, got.strength, got.noise_ratio, got.is_station,
							got.total, got.is_last);
					end
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
		if ((out_valid === 1'b1 && !out_stall) || (in_valid && in_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Watchdog
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int r;
		mismatches    = 0;
		quiet_cycles  = 0;
		beats_sent    = 0;
		send_idle_pct = 26;
		stall_pct     = 53;
		scan_len      = 0;
		band_low      = STRENGTH_MAX;
		band_high     = 8'd0;
		scan_open     = 1'b0;
		freq_base     = 16'd0;
		freq_step     = 16'd1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles lightly, receiver stalls often; reset-value registers
		write_reg(CFG_START_FREQ, 16'd0);
		write_reg(CFG_FREQ_STEP, 16'd1);
		for (r = 0; r < 25; r++)
			send_beat(directed_rows[r].func_code, directed_rows[r].str, directed_rows[r].snr,
				directed_rows[r].typed, directed_rows[r].want);
		run_random(35);

		// Phase two: roles swapped, largest start and step, one scan that fills the list
		drain_results();
		write_reg(CFG_START_FREQ, 16'hFFFF);
		write_reg(CFG_FREQ_STEP, 16'hFFFF);
		send_idle_pct = 53;
		stall_pct     = 26;
		run_random(35);
		run_scan(1, 2 * MAX_ST + 8);

		// Phase three: no idling; zero step, then a random setting
		drain_results();
		write_reg(CFG_START_FREQ, 16'($urandom));
		write_reg(CFG_FREQ_STEP, 16'd0);
		send_idle_pct = 0;
		stall_pct     = 0;
		run_random(20);
		drain_results();
		write_reg(CFG_START_FREQ, 16'($urandom));
		write_reg(CFG_FREQ_STEP, 16'($urandom_range(1, 65535)));
		run_random(20);

		// Wind down
		in_valid <= 1'b0;
		while (expected_stations.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_stations.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/ssp_pkg.sv
rtl/core/ssp_point_store.sv
rtl/core/ssp_station_list.sv
rtl/core/scan_station_peak_finder_core.sv
tb/scan_station_peak_finder_core_test.sv
